// ===== rtl/ycc2rgb_pkg.sv =====
`timescale 1ns / 1ps
// Constants shared by the YCbCr to RGB converter with grey binning.
package ycc2rgb_pkg;

    // Macroblock geometry
    localparam int BLOCK_SIDE = 16;
    localparam int HALF_SIDE  = BLOCK_SIDE / 2;
    localparam int CNT_W      = (BLOCK_SIDE > 2) ? $clog2(BLOCK_SIDE) : 1;
    localparam int SLOT_W     = (HALF_SIDE > 1) ? $clog2(HALF_SIDE) : 1;
    localparam int IDX_CALC_W = 2 * CNT_W + 2;
    localparam int BIN_IDX_W  = 6;

    // Signed width of the scaled color sums (bit 16 is the integer LSB)
    localparam int SUM_W = 28;

    // Coefficients and offsets, scaled by 2^16
    localparam logic signed [SUM_W-1:0] COEF_Y    = 28'sd76293;
    localparam logic signed [SUM_W-1:0] COEF_R_CR = 28'sd104582;
    localparam logic signed [SUM_W-1:0] COEF_R_CB = 28'sd117;
    localparam logic signed [SUM_W-1:0] OFFS_R    = 28'sd14592115;
    localparam logic signed [SUM_W-1:0] COEF_G_CR = 28'sd53314;
    localparam logic signed [SUM_W-1:0] COEF_G_CB = 28'sd25651;
    localparam logic signed [SUM_W-1:0] OFFS_G    = 28'sd8886944;
    localparam logic signed [SUM_W-1:0] COEF_B_CR = 28'sd82;
    localparam logic signed [SUM_W-1:0] COEF_B_CB = 28'sd132241;
    localparam logic signed [SUM_W-1:0] OFFS_B    = 28'sd18137022;

    // floor(s / 3) == (s * 683) >> 11 for every s below 2048
    localparam int             GREY_SUM_W  = 10;
    localparam int             GREY_PROD_W = 21;
    localparam logic [10:0]    GREY_RECIP  = 11'd683;
    localparam int             GREY_SHIFT  = 11;

endpackage

// ===== rtl/ycbcr_to_rgb_grey_bin.sv =====
`timescale 1ns / 1ps
// Top level: YCbCr to RGB conversion with 2x2 grey binning.
// Takes one pixel per clock in raster order over a BLOCK_SIDE x BLOCK_SIDE
// macroblock and returns one beat per pixel, one per clock when the sink keeps
// i_ready high. The path runs through an input register, a register holding
// the clamped RGB values, and the output register holding RGB plus the bin
// result. Grey, the pair sums and the raster position are handled between the
// second and third register, so bins never stall the stream. Each stage
// accepts whenever it is empty or moving on, so a waiting result does not stop
// the earlier stages from filling. bin_grey and bin_index read 0 when
// bin_valid is low; block_done marks the last pixel of a macroblock.
module ycbcr_to_rgb_grey_bin (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // pixel input
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_luma,
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_chroma_red,
    // result output
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_bin_valid,
    output logic [7:0] o_bin_grey,
    output logic [5:0] o_bin_index,
    output logic       o_block_done
);

    localparam int CW = ycc2rgb_pkg::CNT_W;
    localparam int SW = ycc2rgb_pkg::SUM_W;
    localparam int IW = ycc2rgb_pkg::IDX_CALC_W;

    // stage A: registered input
    logic       r_a_valid;
    logic [7:0] r_a_luma, r_a_cb, r_a_cr;
    // stage B: clamped RGB
    logic       r_b_valid;
    logic [7:0] r_b_red, r_b_green, r_b_blue;
    // output stage
    logic       r_out_valid;
    logic [7:0] r_out_red, r_out_green, r_out_blue;
    logic       r_out_bin_valid;
    logic [7:0] r_out_bin_grey;
    logic [5:0] r_out_bin_index;
    logic       r_out_done;

    // raster position and bin state
    logic [CW-1:0] r_col, r_row, n_col, n_row;
    logic [7:0]    r_left_grey;
    logic [8:0]    r_pair_sums [ycc2rgb_pkg::HALF_SIDE];

    // flow control
    logic out_adv, b_move, b_ready, a_move, a_ready;

    assign out_adv = !r_out_valid || i_ready;
    assign b_move  = r_b_valid && out_adv;
    assign b_ready = !r_b_valid || out_adv;
    assign a_move  = r_a_valid && b_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // ---------------- stage A -> B: color matrix and clamp ----------------
    logic signed [SW-1:0] y_s, cb_s, cr_s, y_term;
    logic signed [SW-1:0] sum_r, sum_g, sum_b;
    logic [7:0]           n_red, n_green, n_blue;

    function automatic logic [7:0] clamp_sum(input logic signed [SW-1:0] v);
        logic [7:0] res;
        if (v[SW-1]) begin
            res = 8'd0;
        end else if (|v[SW-2:24]) begin
            res = 8'd255;
        end else begin
            res = v[23:16];
        end
        return res;
    endfunction

    always_comb begin
        y_s    = $signed({{(SW-8){1'b0}}, r_a_luma});
        cb_s   = $signed({{(SW-8){1'b0}}, r_a_cb});
        cr_s   = $signed({{(SW-8){1'b0}}, r_a_cr});
        y_term = ycc2rgb_pkg::COEF_Y * y_s;
        sum_r  = y_term + ycc2rgb_pkg::COEF_R_CR * cr_s
                 - ycc2rgb_pkg::COEF_R_CB * cb_s - ycc2rgb_pkg::OFFS_R;
        sum_g  = y_term - ycc2rgb_pkg::COEF_G_CR * cr_s
                 - ycc2rgb_pkg::COEF_G_CB * cb_s + ycc2rgb_pkg::OFFS_G;
        sum_b  = y_term - ycc2rgb_pkg::COEF_B_CR * cr_s
                 + ycc2rgb_pkg::COEF_B_CB * cb_s - ycc2rgb_pkg::OFFS_B;
        n_red   = clamp_sum(sum_r);
        n_green = clamp_sum(sum_g);
        n_blue  = clamp_sum(sum_b);
    end

    // ---------------- stage B -> out: grey, binning, position ----------------
    logic [ycc2rgb_pkg::GREY_SUM_W-1:0]  grey_sum;
    logic [ycc2rgb_pkg::GREY_PROD_W-1:0] grey_prod;
    logic [7:0]                          grey;
    logic [8:0]                          pair;
    logic [9:0]                          quad;
    logic [ycc2rgb_pkg::SLOT_W-1:0]      slot;
    logic [CW-1:0]                       col_half, row_half;
    logic [IW-1:0]                       idx_full;
    logic                                col_odd, row_odd, col_last, row_last;
    logic                                n_bin_valid, n_done;
    logic [7:0]                          n_bin_grey;
    logic [5:0]                          n_bin_index;

    always_comb begin
        grey_sum  = {2'b00, r_b_red} + {2'b00, r_b_green} + {2'b00, r_b_blue};
        grey_prod = ycc2rgb_pkg::GREY_PROD_W'(grey_sum)
                    * ycc2rgb_pkg::GREY_PROD_W'(ycc2rgb_pkg::GREY_RECIP);
        grey      = grey_prod[ycc2rgb_pkg::GREY_SHIFT +: 8];

        col_odd  = r_col[0];
        row_odd  = r_row[0];
        col_half = r_col >> 1;
        row_half = r_row >> 1;
        // only read on odd columns, where col/2 is always below HALF_SIDE
        slot     = col_half[ycc2rgb_pkg::SLOT_W-1:0];
        pair     = {1'b0, r_left_grey} + {1'b0, grey};
        quad     = {1'b0, r_pair_sums[slot]} + {1'b0, pair};
        idx_full = IW'(row_half) * IW'(ycc2rgb_pkg::HALF_SIDE) + IW'(col_half);

        n_bin_valid = col_odd && row_odd;
        n_bin_grey  = n_bin_valid ? quad[9:2] : 8'd0;
        n_bin_index = n_bin_valid ? idx_full[ycc2rgb_pkg::BIN_IDX_W-1:0] : 6'd0;

        col_last = (r_col == CW'(ycc2rgb_pkg::BLOCK_SIDE - 1));
        row_last = (r_row == CW'(ycc2rgb_pkg::BLOCK_SIDE - 1));
        n_done   = col_last && row_last;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_left_grey <= 8'd0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_b_valid;
            end
            if (b_move) begin
                r_col <= n_col;
                r_row <= n_row;
                if (!col_odd) begin
                    r_left_grey <= grey;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_luma <= i_luma;
            r_a_cb   <= i_chroma_blue;
            r_a_cr   <= i_chroma_red;
        end
        if (a_move) begin
            r_b_red   <= n_red;
            r_b_green <= n_green;
            r_b_blue  <= n_blue;
        end
        if (b_move) begin
            r_out_red       <= r_b_red;
            r_out_green     <= r_b_green;
            r_out_blue      <= r_b_blue;
            r_out_bin_valid <= n_bin_valid;
            r_out_bin_grey  <= n_bin_grey;
            r_out_bin_index <= n_bin_index;
            r_out_done      <= n_done;
            // even row: keep the horizontal pair for the row below
            if (col_odd && !row_odd) begin
                r_pair_sums[slot] <= pair;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red        = r_out_red;
    assign o_green      = r_out_green;
    assign o_blue       = r_out_blue;
    assign o_bin_valid  = r_out_bin_valid;
    assign o_bin_grey   = r_out_bin_grey;
    assign o_bin_index  = r_out_bin_index;
    assign o_block_done = r_out_done;

endmodule
